[rtl/clock_page_replacement_top_macros.svh]
// Assertion macros for the clock page replacement top level.
`ifndef CLOCK_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cpr_pkg.sv]
// Types and constants for the clock page replacement block.
`default_nettype none

package cpr_pkg;

  // Width of the frame count register.
  localparam int unsigned FcWidth = 4;

  // Width of the result ports that have a fixed size.
  localparam int unsigned FrameOutWidth = 3;
  localparam int unsigned PageOutWidth  = 8;
  localparam int unsigned FaultWidth    = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_EVICT
  } cpr_state_e;

endpackage

`default_nettype wire

[rtl/cpr_page_ram.sv]
// Resident page table: one write port, one registered read port.
`default_nettype none

module cpr_page_ram #(
  parameter int unsigned Depth     = 8,
  parameter int unsigned AddrWidth = 3,
  parameter int unsigned DataWidth = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [DataWidth-1:0] wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [DataWidth-1:0] rdata_o
);

  logic [DataWidth-1:0] mem [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/clock_page_replacement_top.sv]
// Top level of the clock (second chance) page replacement unit.
`default_nettype none

// Clock page replacement unit. Pulse start with a page number while busy is
// low; the reference is transferred on that edge and busy rises. The result
// (hit, frame, evicted page, running fault count) appears for exactly one
// cycle with done_o high, and busy is low again in that same cycle, so a new
// start can be issued right away. The receiver cannot stall: capture the
// result when done_o is high. A single page comparator walks the page table
// one entry per cycle through the table's registered read port. On a hit the
// entry's use bit is set; on a miss while the table fills, the page goes to
// the next free entry; on a miss on a full table, the hand tests one use bit
// per cycle, clears each set bit that it passes and evicts the first frame
// whose use bit is clear. Write frame_count only while busy is low; 0 acts
// as 1 and values above FRAMES act as FRAMES. The page table needs no
// clearing after reset: only entries below the fill count are ever read.
module clock_page_replacement_top
  import cpr_pkg::*;
#(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [PageOutWidth-1:0]  page_i,
  input  wire logic                     frame_count_we_i,
  input  wire logic [FcWidth-1:0]       frame_count_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [FrameOutWidth-1:0]      frame_o,
  output logic                          evicted_valid_o,
  output logic [PageOutWidth-1:0]       evicted_page_o,
  output logic [FaultWidth-1:0]         fault_count_o
);

  `include "clock_page_replacement_top_macros.svh"

  // Frame index width and count width (a count can reach FRAMES itself).
  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);

  cpr_state_e state_q, state_d;

  logic [FcWidth-1:0]    fc_q;
  logic [PAGE_BITS-1:0]  pg_q, pg_d;
  logic [CW-1:0]         addr_q, addr_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [FW-1:0]         rd_idx_q, rd_idx_d;
  logic [FW-1:0]         hand_q, hand_d;
  logic [CW-1:0]         filled_q, filled_d;
  logic [FRAMES-1:0]     use_q, use_d;
  logic [FaultWidth-1:0] faults_q, faults_d;

  // Result registers.
  logic                  done_q, done_d;
  logic                  hit_q, hit_d;
  logic [FW-1:0]         frame_q, frame_d;
  logic                  ev_vld_q, ev_vld_d;
  logic [PAGE_BITS-1:0]  ev_page_q, ev_page_d;

  // Page table port.
  logic                  ram_we;
  logic [FW-1:0]         ram_waddr;
  logic                  ram_re;
  logic [FW-1:0]         ram_raddr;
  logic [PAGE_BITS-1:0]  ram_rdata;

  logic [CW-1:0]         n_act;
  logic [CW:0]           hand_inc;
  logic [FW-1:0]         hand_nxt;

  cpr_page_ram #(
    .Depth     (FRAMES),
    .AddrWidth (FW),
    .DataWidth (PAGE_BITS)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (pg_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Saturate the configured frame count into 1..FRAMES.
  always_comb begin
    if (fc_q == '0) begin
      n_act = CW'(1);
    end else if (32'(fc_q) > 32'(FRAMES)) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(fc_q);
    end
  end

  // Advance the hand with wrap at the active frame count.
  assign hand_inc = {1'b0, CW'(hand_q)} + (CW + 1)'(1);
  assign hand_nxt = (hand_inc >= {1'b0, n_act}) ? '0 : hand_inc[FW-1:0];

  // Sequencer: one comparator walks the table, then on a miss with a full table the hand walks use bits.
  always_comb begin
    state_d   = state_q;
    pg_d      = pg_q;
    addr_d    = addr_q;
    rd_vld_d  = rd_vld_q;
    rd_idx_d  = rd_idx_q;
    hand_d    = hand_q;
    filled_d  = filled_q;
    use_d     = use_q;
    faults_d  = faults_q;
    done_d    = 1'b0;
    hit_d     = hit_q;
    frame_d   = frame_q;
    ev_vld_d  = ev_vld_q;
    ev_page_d = ev_page_q;
    ram_we    = 1'b0;
    ram_waddr = hand_q;
    ram_re    = 1'b0;
    ram_raddr = addr_q[FW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          pg_d     = PAGE_BITS'(page_i);
          addr_d   = '0;
          rd_vld_d = 1'b0;
          // Clip fill count and hand to a lowered frame count.
          if (filled_q > n_act) begin
            filled_d = n_act;
          end
          if (CW'(hand_q) >= n_act) begin
            hand_d = '0;
          end
          state_d = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (rd_vld_q && (ram_rdata == pg_q)) begin
          use_d[rd_idx_q] = 1'b1;
          done_d    = 1'b1;
          hit_d     = 1'b1;
          frame_d   = rd_idx_q;
          ev_vld_d  = 1'b0;
          ev_page_d = '0;
          rd_vld_d  = 1'b0;
          state_d   = ST_IDLE;
        end else if (addr_q < filled_q) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q[FW-1:0];
          addr_d   = addr_q + CW'(1);
        end else begin
          // Miss: every resident page compared unequal.
          rd_vld_d = 1'b0;
          if (faults_q != '1) begin
            faults_d = faults_q + FaultWidth'(1);
          end
          if (filled_q < n_act) begin
            ram_we    = 1'b1;
            ram_waddr = filled_q[FW-1:0];
            use_d[filled_q[FW-1:0]] = 1'b1;
            filled_d  = filled_q + CW'(1);
            done_d    = 1'b1;
            hit_d     = 1'b0;
            frame_d   = filled_q[FW-1:0];
            ev_vld_d  = 1'b0;
            ev_page_d = '0;
            state_d   = ST_IDLE;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        if (use_q[hand_q]) begin
          // Give this frame its second chance.
          use_d[hand_q] = 1'b0;
          hand_d = hand_nxt;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = hand_q;
          state_d   = ST_EVICT;
        end
      end

      ST_EVICT: begin
        ram_we        = 1'b1;
        ram_waddr     = hand_q;
        use_d[hand_q] = 1'b1;
        done_d        = 1'b1;
        hit_d         = 1'b0;
        frame_d       = hand_q;
        ev_vld_d      = 1'b1;
        ev_page_d     = ram_rdata;
        hand_d        = hand_nxt;
        state_d       = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fc_q     <= FcWidth'(8);
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      hand_q   <= '0;
      filled_q <= '0;
      use_q    <= '0;
      faults_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      rd_vld_q <= rd_vld_d;
      hand_q   <= hand_d;
      filled_q <= filled_d;
      use_q    <= use_d;
      faults_q <= faults_d;
      done_q   <= done_d;
      if (frame_count_we_i) begin
        fc_q <= frame_count_i;
      end
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    pg_q      <= pg_d;
    rd_idx_q  <= rd_idx_d;
    hit_q     <= hit_d;
    frame_q   <= frame_d;
    ev_vld_q  <= ev_vld_d;
    ev_page_q <= ev_page_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_o         = FrameOutWidth'(frame_q);
  assign evicted_valid_o = ev_vld_q;
  assign evicted_page_o  = PageOutWidth'(ev_page_q);
  assign fault_count_o   = faults_q;

  `CPR_ASSERT(a_done_when_idle, done_o |-> !busy, "result strobe while still busy")
  `CPR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer did not raise busy")
  `CPR_ASSERT(a_fill_bound, filled_q <= CW'(FRAMES), "fill count beyond frame table")
  `CPR_ASSERT(a_evict_on_miss, (done_o && evicted_valid_o) |-> !hit_o, "eviction reported on a hit")
  `CPR_ASSERT(a_fault_counted, (done_o && !hit_o) |-> (fault_count_o != '0),
              "fault reported with zero fault count")

endmodule

`default_nettype wire
